FILE: rtl/acus_pkg.sv
// ----------------------------------------------------------------------------
// acus_pkg
// shared types, constants and the cordic angle table of the arccosine unit
// ----------------------------------------------------------------------------
package acus_pkg;

	localparam int INPUT_BITS_DEF    = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	localparam int ANGLE_W = 24;
	localparam int MODE_W  = 2;
	// cordic datapath: vector normalized to 2^58, gain and sums stay below 2^60
	localparam int XW      = 62;
	localparam int NORM_EXP = 60;
	// phase in turns, 32 fraction bits, with sign and headroom
	localparam int ZW      = 34;
	localparam int PROD_W  = 64;

	localparam logic [31:0] HALF_TURN    = 32'd2147483648;
	localparam logic [31:0] QUARTER_TURN = 32'd1073741824;
	// 2*pi in q3.29
	localparam logic [31:0] TWO_PI_Q29   = 32'd3373259426;
	localparam logic [31:0] DEG_SCALE    = 32'd360;
	localparam logic [31:0] TURN_SCALE   = 32'd1;

	localparam int RAD_SHIFT = 45;
	localparam int STD_SHIFT = 16;

	typedef enum logic [MODE_W-1:0] {
		UNIT_TURNS   = 2'd0,
		UNIT_RADIANS = 2'd1,
		UNIT_DEGREES = 2'd2
	} unit_t;

	// control travelling beside the datapath
	typedef struct packed {
		logic valid;
		logic neg;
		logic clipped;
	} tag_t;

	// atan(2^-i) in turns, 32 fraction bits
	function automatic logic [31:0] atan_turns(input logic [4:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			5'd30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/acus_cfg_if.sv
// ----------------------------------------------------------------------------
// acus_cfg_if
// configuration write channel: unit mode register data
// ----------------------------------------------------------------------------
interface acus_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [acus_pkg::MODE_W-1:0] unit_mode;

	modport source (output valid, output unit_mode, input ready);
	modport sink (input valid, input unit_mode, output ready);
endinterface

FILE: rtl/acus_sample_if.sv
// ----------------------------------------------------------------------------
// acus_sample_if
// input channel: one signed fixed-point sample per transaction
// ----------------------------------------------------------------------------
interface acus_sample_if #(
	parameter int W = acus_pkg::INPUT_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

FILE: rtl/acus_result_if.sv
// ----------------------------------------------------------------------------
// acus_result_if
// output channel: scaled angle and saturation flag per transaction
// ----------------------------------------------------------------------------
interface acus_result_if;
	logic                         valid;
	logic                         ready;
	logic [acus_pkg::ANGLE_W-1:0] angle;
	logic                         clipped;

	modport source (output valid, output angle, output clipped, input ready);
	modport sink (input valid, input angle, input clipped, output ready);
endinterface

FILE: rtl/acus_sqrt_cell.sv
// ----------------------------------------------------------------------------
// acus_sqrt_cell
// one digit of a pipelined restoring integer square root
// ----------------------------------------------------------------------------
module acus_sqrt_cell #(
	parameter int INPUT_BITS = acus_pkg::INPUT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  acus_pkg::tag_t            tag_in,
	input  logic [2*(INPUT_BITS-1)-1:0] rad_in,
	input  logic [INPUT_BITS:0]       rem_in,
	input  logic [INPUT_BITS-2:0]     root_in,
	input  logic [INPUT_BITS-2:0]     mag_in,
	output acus_pkg::tag_t            tag_q,
	output logic [2*(INPUT_BITS-1)-1:0] rad_q,
	output logic [INPUT_BITS:0]       rem_q,
	output logic [INPUT_BITS-2:0]     root_q,
	output logic [INPUT_BITS-2:0]     mag_q
);
	localparam int RADW = 2 * (INPUT_BITS - 1);
	localparam int CW   = INPUT_BITS + 3;

	logic [CW-1:0] cur;
	logic [CW-1:0] trial;
	logic          fits;

	// bring down the next two radicand bits, try root*4+1
	assign cur   = {rem_in, rad_in[RADW-1 -: 2]};
	assign trial = {{(CW-INPUT_BITS-1){1'b0}}, root_in, 2'b01};
	assign fits  = (cur >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (en) begin
			tag_q <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= {rad_in[RADW-3:0], 2'b00};
			mag_q  <= mag_in;
			if (fits) begin
				rem_q  <= (INPUT_BITS+1)'(cur - trial);
				root_q <= {root_in[INPUT_BITS-3:0], 1'b1};
			end else begin
				rem_q  <= (INPUT_BITS+1)'(cur);
				root_q <= {root_in[INPUT_BITS-3:0], 1'b0};
			end
		end
	end
endmodule

FILE: rtl/acus_cordic_cell.sv
// ----------------------------------------------------------------------------
// acus_cordic_cell
// one vectoring micro-rotation with its phase update
// ----------------------------------------------------------------------------
module acus_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  acus_pkg::tag_t                 tag_in,
	input  logic signed [acus_pkg::XW-1:0] x_in,
	input  logic signed [acus_pkg::XW-1:0] y_in,
	input  logic signed [acus_pkg::ZW-1:0] z_in,
	output acus_pkg::tag_t                 tag_q,
	output logic signed [acus_pkg::XW-1:0] x_q,
	output logic signed [acus_pkg::XW-1:0] y_q,
	output logic signed [acus_pkg::ZW-1:0] z_q
);
	logic signed [acus_pkg::XW-1:0] dx;
	logic signed [acus_pkg::XW-1:0] dy;
	logic signed [acus_pkg::ZW-1:0] step;

	// arithmetic shift gives floor division
	assign dx   = y_in >>> STAGE;
	assign dy   = x_in >>> STAGE;
	assign step = signed'({{(acus_pkg::ZW-32){1'b0}}, acus_pkg::atan_turns(5'(STAGE))});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (en) begin
			tag_q <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[acus_pkg::XW-1]) begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + step;
			end else begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - step;
			end
		end
	end
endmodule

FILE: rtl/acus_scale.sv
// ----------------------------------------------------------------------------
// acus_scale
// phase clamp, unit multiply and rounding to 16 fraction bits
// ----------------------------------------------------------------------------
module acus_scale (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic [acus_pkg::MODE_W-1:0]    unit_mode,
	input  acus_pkg::tag_t                 tag_in,
	input  logic signed [acus_pkg::ZW-1:0] z_in,
	output acus_pkg::tag_t                 tag_out,
	output logic [acus_pkg::ANGLE_W-1:0]   angle
);
	logic [31:0]                   z_clamp;
	logic [31:0]                   z_s1;
	acus_pkg::tag_t                tag_s1;
	logic [31:0]                   scale;
	logic [acus_pkg::PROD_W-1:0]   prod_s2;
	acus_pkg::tag_t                tag_s2;
	logic [acus_pkg::PROD_W-1:0]   rnd;
	logic [acus_pkg::PROD_W-1:0]   sum;

	// keep cordic residue inside zero to half a turn
	always_comb begin
		if (z_in[acus_pkg::ZW-1]) begin
			z_clamp = '0;
		end else if (z_in > signed'({{(acus_pkg::ZW-32){1'b0}}, acus_pkg::HALF_TURN})) begin
			z_clamp = acus_pkg::HALF_TURN;
		end else begin
			z_clamp = z_in[31:0];
		end
	end

	always_comb begin
		case (unit_mode)
			acus_pkg::UNIT_RADIANS: scale = acus_pkg::TWO_PI_Q29;
			acus_pkg::UNIT_DEGREES: scale = acus_pkg::DEG_SCALE;
			default:                scale = acus_pkg::TURN_SCALE;
		endcase
	end

	always_comb begin
		case (unit_mode)
			acus_pkg::UNIT_RADIANS: rnd = acus_pkg::PROD_W'(1) << (acus_pkg::RAD_SHIFT - 1);
			default:                rnd = acus_pkg::PROD_W'(1) << (acus_pkg::STD_SHIFT - 1);
		endcase
	end

	assign sum = prod_s2 + rnd;

	always_comb begin
		case (unit_mode)
			acus_pkg::UNIT_RADIANS: angle = acus_pkg::ANGLE_W'(sum >> acus_pkg::RAD_SHIFT);
			default:                angle = acus_pkg::ANGLE_W'(sum >> acus_pkg::STD_SHIFT);
		endcase
	end

	assign tag_out = tag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (en) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1    <= z_clamp;
			prod_s2 <= acus_pkg::PROD_W'(z_s1) * acus_pkg::PROD_W'(scale);
		end
	end
endmodule

FILE: rtl/arccosine_unit_scaled.sv
// ----------------------------------------------------------------------------
// arccosine_unit_scaled
// fixed-point arccosine with selectable output unit
// ----------------------------------------------------------------------------
// Takes one signed sample per transaction (1.0 = 2^(INPUT_BITS-2)), saturates
// it to -1..1 and returns acos(sample) in turns, radians or degrees, as an
// unsigned value with 16 fraction bits, plus a flag that marks saturation.
// The arccosine is atan2(sqrt(1-x^2), x): a square and subtract, an exact
// integer square root built as a chain of INPUT_BITS-1 digit cells, then a
// chain of CORDIC_STAGES vectoring cells, a phase clamp and a unit multiply.
// Every cell hands its item to the next one each cycle while the chain is
// enabled, so a new sample is taken every clock unless the skid register is
// full. A result that waits at the output does not stop the chain:
// a second result parks in a skid register, and only then does the input
// ready drop. The unit mode register is written over the cfg channel, which
// is always ready; write it only while no transaction is in flight. Mode
// three reads as turns.
// ----------------------------------------------------------------------------
module arccosine_unit_scaled #(
	parameter int INPUT_BITS    = acus_pkg::INPUT_BITS_DEF,
	parameter int CORDIC_STAGES = acus_pkg::CORDIC_STAGES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	acus_cfg_if.sink       cfg,
	acus_sample_if.sink    samples,
	acus_result_if.source  results
);
	localparam int IB   = INPUT_BITS;
	localparam int CS   = CORDIC_STAGES;
	localparam int RADW = 2 * (IB - 1);
	localparam int UP   = acus_pkg::NORM_EXP - IB;
	localparam int XW   = acus_pkg::XW;
	localparam int ZW   = acus_pkg::ZW;
	localparam logic signed [IB-1:0] ONE     = {2'b01, {(IB-2){1'b0}}};
	localparam logic signed [IB-1:0] NEG_ONE = -ONE;
	localparam logic [RADW-1:0]      ONE_SQ  = RADW'(1) << (2 * IB - 4);

	// unit mode register
	logic [acus_pkg::MODE_W-1:0] unit_mode_q;

	// chain enable: stops only when the skid register is occupied
	logic en;

	// input saturation stage
	logic signed [IB-1:0] smp;
	logic signed [IB-1:0] smp_neg;
	logic [IB-2:0]        mag_in;
	acus_pkg::tag_t       tag_in;
	logic [IB-2:0]        mag_s1;
	acus_pkg::tag_t       tag_s1;

	// square stage
	logic [RADW-1:0]      sq;
	logic [RADW-1:0]      rad_s2;
	logic [IB-2:0]        mag_s2;
	acus_pkg::tag_t       tag_s2;

	// square root chain, index 0 feeds the first cell
	acus_pkg::tag_t       sq_tag  [0:IB-1];
	logic [RADW-1:0]      sq_rad  [0:IB-1];
	logic [IB:0]          sq_rem  [0:IB-1];
	logic [IB-2:0]        sq_root [0:IB-1];
	logic [IB-2:0]        sq_mag  [0:IB-1];

	// cordic chain
	acus_pkg::tag_t       cr_tag [0:CS];
	logic signed [XW-1:0] cr_x   [0:CS];
	logic signed [XW-1:0] cr_y   [0:CS];
	logic signed [ZW-1:0] cr_z   [0:CS];

	// scaling and output
	acus_pkg::tag_t               tail_tag;
	logic [acus_pkg::ANGLE_W-1:0] tail_angle;
	logic                         arrive;
	logic                         pop;
	logic                         out_valid_q;
	logic [acus_pkg::ANGLE_W-1:0] out_angle_q;
	logic                         out_clipped_q;
	logic                         skid_valid_q;
	logic [acus_pkg::ANGLE_W-1:0] skid_angle_q;
	logic                         skid_clipped_q;

	// configuration write
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_mode_q <= acus_pkg::UNIT_TURNS;
		end else if (cfg.valid) begin
			unit_mode_q <= cfg.unit_mode;
		end
	end

	assign en            = !skid_valid_q;
	assign samples.ready = en;

	// saturate to -1..1 and split into sign and magnitude
	assign smp     = samples.sample;
	assign smp_neg = -smp;

	always_comb begin
		tag_in.valid = samples.valid;
		if (smp > ONE) begin
			mag_in         = ONE[IB-2:0];
			tag_in.neg     = 1'b0;
			tag_in.clipped = 1'b1;
		end else if (smp < NEG_ONE) begin
			mag_in         = ONE[IB-2:0];
			tag_in.neg     = 1'b1;
			tag_in.clipped = 1'b1;
		end else if (smp[IB-1]) begin
			mag_in         = smp_neg[IB-2:0];
			tag_in.neg     = 1'b1;
			tag_in.clipped = 1'b0;
		end else begin
			mag_in         = smp[IB-2:0];
			tag_in.neg     = 1'b0;
			tag_in.clipped = 1'b0;
		end
	end

	// radicand 1 - x^2, with 1.0 = 2^(2*INPUT_BITS-4)
	assign sq = RADW'(mag_s1) * RADW'(mag_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (en) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_in;
			mag_s2 <= mag_s1;
			rad_s2 <= ONE_SQ - sq;
		end
	end

	assign sq_tag[0]  = tag_s2;
	assign sq_rad[0]  = rad_s2;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_mag[0]  = mag_s2;

	// one root bit per cell
	for (genvar k = 0; k < IB - 1; k++) begin : g_sqrt
		acus_sqrt_cell #(
			.INPUT_BITS (IB)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.tag_in  (sq_tag[k]),
			.rad_in  (sq_rad[k]),
			.rem_in  (sq_rem[k]),
			.root_in (sq_root[k]),
			.mag_in  (sq_mag[k]),
			.tag_q   (sq_tag[k+1]),
			.rad_q   (sq_rad[k+1]),
			.rem_q   (sq_rem[k+1]),
			.root_q  (sq_root[k+1]),
			.mag_q   (sq_mag[k+1])
		);
	end

	// cordic entry: negative x is turned a quarter turn first, so the
	// vector always sits in the first quadrant
	always_comb begin
		cr_tag[0] = sq_tag[IB-1];
		if (sq_tag[IB-1].neg) begin
			cr_x[0] = signed'({{(XW-IB+1){1'b0}}, sq_root[IB-1]} << UP);
			cr_y[0] = signed'({{(XW-IB+1){1'b0}}, sq_mag[IB-1]} << UP);
			cr_z[0] = signed'({{(ZW-32){1'b0}}, acus_pkg::QUARTER_TURN});
		end else begin
			cr_x[0] = signed'({{(XW-IB+1){1'b0}}, sq_mag[IB-1]} << UP);
			cr_y[0] = signed'({{(XW-IB+1){1'b0}}, sq_root[IB-1]} << UP);
			cr_z[0] = '0;
		end
	end

	for (genvar i = 0; i < CS; i++) begin : g_cordic
		acus_cordic_cell #(
			.STAGE (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.tag_in (cr_tag[i]),
			.x_in   (cr_x[i]),
			.y_in   (cr_y[i]),
			.z_in   (cr_z[i]),
			.tag_q  (cr_tag[i+1]),
			.x_q    (cr_x[i+1]),
			.y_q    (cr_y[i+1]),
			.z_q    (cr_z[i+1])
		);
	end

	acus_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.unit_mode (unit_mode_q),
		.tag_in    (cr_tag[CS]),
		.z_in      (cr_z[CS]),
		.tag_out   (tail_tag),
		.angle     (tail_angle)
	);

	// output register with a one-entry skid behind it
	assign arrive = en && tail_tag.valid;
	assign pop    = out_valid_q && results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (arrive) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_angle_q   <= skid_angle_q;
				out_clipped_q <= skid_clipped_q;
			end
		end else if (arrive) begin
			if (!out_valid_q || pop) begin
				out_angle_q   <= tail_angle;
				out_clipped_q <= tail_tag.clipped;
			end else begin
				skid_angle_q   <= tail_angle;
				skid_clipped_q <= tail_tag.clipped;
			end
		end
	end

	assign results.valid   = out_valid_q;
	assign results.angle   = out_angle_q;
	assign results.clipped = out_clipped_q;

	// skid holds a transaction only behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid occupied while output register empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !results.ready))
		else $error("skid filled without output stall");

	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(results.ready))
		else $error("result dropped without transaction");

	// square root remainder never exceeds twice the root
	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		sq_tag[IB-1].valid |-> ({1'b0, sq_rem[IB-1]} <= {1'b0, sq_root[IB-1], 1'b0}))
		else $error("square root remainder out of range");

	// all radicand digits consumed at the end of the root chain
	a_sqrt_done: assert property (@(posedge clk) disable iff (!arst_n)
		sq_tag[IB-1].valid |-> (sq_rad[IB-1] == '0))
		else $error("radicand not fully consumed");
endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the scaled arccosine unit
// ----------------------------------------------------------------------------
// Feeds signed q1.14 samples through the sample channel and checks every
// result transaction against a bit-exact behavioral model of the integer
// square root, the cordic vectoring pass, the phase clamp and the unit
// scaling. Runs a set of corner samples first, then random phases under every
// unit mode, including the reserved one. Both channels idle at random, and in
// two phases the result side chokes long enough to back up the whole pipe.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          HALF_PERIOD   = 6;
	localparam int          RESET_CYCLES  = 10;
	// pipeline depth at the default widths; the drain time adds margin for the skid stage
	localparam int          PIPE_DEPTH    = 36;
	localparam int          DRAIN_CYCLES  = PIPE_DEPTH + 12;
	localparam int          CHOKE_CYCLES  = 400;
	localparam int          PHASE_ITEMS   = 330;
	localparam longint      TIMEOUT_NS    = 64'd30_000_000;
	// 1.0 in the sample format, and the shift that normalizes the vector
	localparam longint      UNITY         = 64'd16384;
	localparam int          NORM_SHIFT    = 44;
	// the fourth mode code has no enum member; it reads as turns
	localparam logic [acus_pkg::MODE_W-1:0] UNIT_RESERVED = 2'd3;

	typedef struct {
		logic [acus_pkg::ANGLE_W-1:0] angle;
		logic                         clipped;
	} acos_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// bench-side drive registers, known from time zero
	logic                          smp_valid = 1'b0;
	logic signed [15:0]            smp_data  = '0;
	logic                          res_ready = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic [acus_pkg::MODE_W-1:0]   cfg_mode  = '0;

	acus_cfg_if               cfg_ch ();
	acus_sample_if #(.W(16))  smp_ch ();
	acus_result_if            res_ch ();

	assign cfg_ch.valid     = cfg_valid;
	assign cfg_ch.unit_mode = cfg_mode;
	assign smp_ch.valid     = smp_valid;
	assign smp_ch.sample    = smp_data;
	assign res_ch.ready     = res_ready;

	arccosine_unit_scaled dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.samples (smp_ch),
		.results (res_ch)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// samples waiting to be offered, and angles waiting to come back
	logic signed [15:0] pending_samples[$];
	acos_result_t       expected_angles[$];

	int unsigned samples_queued   = 0;
	int unsigned samples_accepted = 0;
	int unsigned error_count      = 0;
	int unsigned choke_requests   = 0;
	int unsigned choke_served     = 0;
	bit          calm             = 1'b0;
	logic [acus_pkg::MODE_W-1:0] unit_mirror = acus_pkg::UNIT_TURNS;

	// atan(2^-i) in turns, 32 fraction bits
	function automatic longint cordic_arc(input int i);
		case (i)
			0:  return 64'd536870912;
			1:  return 64'd316933406;
			2:  return 64'd167458907;
			3:  return 64'd85004756;
			4:  return 64'd42667331;
			5:  return 64'd21354465;
			6:  return 64'd10679838;
			7:  return 64'd5340245;
			8:  return 64'd2670163;
			9:  return 64'd1335087;
			10: return 64'd667544;
			11: return 64'd333772;
			12: return 64'd166886;
			13: return 64'd83443;
			14: return 64'd41722;
			15: return 64'd20861;
			default: return 64'd0;
		endcase
	endfunction

	// floor square root; the radicand never exceeds 2^28
	function automatic longint floor_sqrt(input longint n);
		longint root;
		longint trial;
		root = 0;
		for (int b = 15; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= n)
				root = trial;
		end
		return root;
	endfunction

	// acos as atan2(sqrt(1 - x^2), x) through a 16-stage cordic in turns
	function automatic acos_result_t acos_predict(input logic signed [15:0] s,
			input logic [acus_pkg::MODE_W-1:0] mode);
		longint       v, mag, ys, x, y, z, dx, dy, nx;
		logic [63:0]  zu, scaled;
		acos_result_t r;
		v         = s;
		r.clipped = 1'b0;
		if (v > UNITY) begin
			v         = UNITY;
			r.clipped = 1'b1;
		end
		if (v < -UNITY) begin
			v         = -UNITY;
			r.clipped = 1'b1;
		end
		mag = (v < 0) ? -v : v;
		ys  = floor_sqrt(UNITY * UNITY - mag * mag);
		// negative x: pre-rotate by a quarter turn so cordic stays in 0..90 deg
		if (v < 0) begin
			x = ys <<< NORM_SHIFT;
			y = mag <<< NORM_SHIFT;
			z = longint'(acus_pkg::QUARTER_TURN);
		end else begin
			x = mag <<< NORM_SHIFT;
			y = ys <<< NORM_SHIFT;
			z = 0;
		end
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				nx = x + dx;
				y  = y - dy;
				z  = z + cordic_arc(i);
			end else begin
				nx = x - dx;
				y  = y + dy;
				z  = z - cordic_arc(i);
			end
			x = nx;
		end
		// clamp residue at the endpoints to 0..half a turn
		if (z < 0)
			z = 0;
		if (z > longint'(acus_pkg::HALF_TURN))
			z = longint'(acus_pkg::HALF_TURN);
		zu = z;
		case (mode)
			acus_pkg::UNIT_RADIANS:
				scaled = (zu * 64'(acus_pkg::TWO_PI_Q29) + (64'd1 << 44)) >> 45;
			acus_pkg::UNIT_DEGREES:
				scaled = (zu * 64'd360 + (64'd1 << 15)) >> 16;
			default:
				scaled = (zu + (64'd1 << 15)) >> 16;
		endcase
		r.angle = scaled[acus_pkg::ANGLE_W-1:0];
		return r;
	endfunction

	// idle stretch: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// biased sample: mostly in range, a good share at the saturation edges,
	// and the rest over the whole 16-bit field
	function automatic logic signed [15:0] rand_sample();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 65)
			v = int'($urandom_range(0, 32768)) - 16384;
		else if (r < 85)
			v = 16384 + int'($urandom_range(0, 16)) - 8;
		else
			v = $urandom;
		if (r >= 65 && r < 85 && $urandom_range(0, 1))
			v = -v;
		return v[15:0];
	endfunction

	// sample driver: holds a transaction until it is taken, then maybe idles
	int idle_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			smp_valid <= 1'b0;
			idle_left = 0;
		end else if (!smp_valid || smp_ch.ready) begin
			if (idle_left > 0) begin
				idle_left--;
				smp_valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				smp_valid <= 1'b1;
				smp_data  <= pending_samples.pop_front();
				idle_left = calm ? 0 : idle_len();
			end else begin
				smp_valid <= 1'b0;
			end
		end
	end

	// result sink: random stalls, plus a long choke on request
	int hold_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (choke_served != choke_requests) begin
				choke_served++;
				hold_left = CHOKE_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (calm) begin
				res_ready <= 1'b1;
			end else begin
				hold_left = idle_len();
				res_ready <= (hold_left == 0);
				if (hold_left > 0)
					hold_left--;
			end
		end
	end

	// monitor: mirrors the mode register, predicts on accepted samples and
	// compares every result transaction with the oldest prediction
	always @(posedge clk) begin
		acos_result_t want;
		if (!arst_n) begin
			unit_mirror = acus_pkg::UNIT_TURNS;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready)
				unit_mirror = cfg_ch.unit_mode;
			if (smp_ch.valid && smp_ch.ready) begin
				expected_angles.push_back(acos_predict(smp_ch.sample, unit_mirror));
				samples_accepted++;
			end
			if (res_ch.valid && res_ch.ready) begin
				if (expected_angles.size() == 0) begin
					$error("unexpected result: angle %0d clipped %0d",
						res_ch.angle, res_ch.clipped);
					error_count++;
				end else begin
					want = expected_angles.pop_front();
					if (res_ch.angle !== want.angle) begin
						$error("angle: expected %0d, actual %0d", want.angle, res_ch.angle);
						error_count++;
					end
					if (res_ch.clipped !== want.clipped) begin
						$error("clipped: expected %0d, actual %0d",
							want.clipped, res_ch.clipped);
						error_count++;
					end
				end
			end
		end
	end

	// queue a sample from the falling edge so the driver sees it cleanly
	task automatic queue_sample(input logic signed [15:0] s);
		pending_samples.push_back(s);
		samples_queued++;
	endtask

	// wait until every transaction has been taken and every result returned
	task automatic wait_idle();
		while (samples_accepted != samples_queued || expected_angles.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one write on the cfg channel, only while the unit is idle
	task automatic write_unit(input logic [acus_pkg::MODE_W-1:0] mode);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_mode  <= mode;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_valid <= 1'b0;
	endtask

	// random phase: both saturation limits and zero, then biased random samples
	task automatic run_phase(input logic [acus_pkg::MODE_W-1:0] mode, input bit choke,
			input bit steady);
		write_unit(mode);
		@(negedge clk);
		calm = steady;
		queue_sample(16'sh4000);
		queue_sample(16'shC000);
		queue_sample(16'sh0000);
		for (int n = 0; n < PHASE_ITEMS; n++)
			queue_sample(rand_sample());
		// the sender keeps offering while the sink holds off for a long stretch
		if (choke)
			choke_requests++;
		wait_idle();
		@(negedge clk);
		calm = 1'b0;
	endtask

	initial begin
		logic signed [15:0] corners[$];
		corners = '{
			16'sh4000, 16'shC000, 16'sh0000, 16'sh0001, 16'shFFFF,
			16'sh7FFF, 16'sh8000, 16'sh4001, 16'shBFFF, 16'sh3FFF,
			16'shC001, 16'sh2000, 16'shE000, 16'sh2D41, 16'shD2BF,
			16'sh5555, 16'shAAAA, 16'sh0064, 16'shFF9C
		};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// corner samples under the reset mode (turns): both saturation
		// limits and beyond, zero, tiny values and the 45 degree points
		@(negedge clk);
		foreach (corners[k])
			queue_sample(corners[k]);
		wait_idle();

		run_phase(acus_pkg::UNIT_DEGREES, 1'b0, 1'b0);
		run_phase(acus_pkg::UNIT_RADIANS, 1'b1, 1'b0);
		run_phase(UNIT_RESERVED, 1'b0, 1'b0);
		run_phase(acus_pkg::UNIT_TURNS, 1'b0, 1'b1);
		run_phase(acus_pkg::UNIT_RADIANS, 1'b0, 1'b0);
		run_phase(acus_pkg::UNIT_DEGREES, 1'b1, 1'b0);

		if (error_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// watchdog for a hung handshake
	initial begin
		#(TIMEOUT_NS);
		$display("testbench: FAIL");
		$finish;
	end

endmodule

FILE: arccosine_unit_scaled.f
rtl/acus_pkg.sv
rtl/acus_cfg_if.sv
rtl/acus_sample_if.sv
rtl/acus_result_if.sv
rtl/acus_sqrt_cell.sv
rtl/acus_cordic_cell.sv
rtl/acus_scale.sv
rtl/arccosine_unit_scaled.sv
bench/testbench.sv
